@@ hdl/prmr_pkg.sv @@
// Package for the primitive root block: widths and defaults.
// Used by prmr_divider and primitive_root_mod_prime.
`default_nettype none
package prmr_pkg;
    localparam int unsigned W = 16;
    localparam int unsigned LARGEST_PRIME_DEF = 65521;
    localparam int unsigned FACTOR_SLOTS_DEF = 8;
endpackage
`default_nettype wire

@@ hdl/prmr_divider.sv @@
// Shared restoring divider: 32-bit dividend by 16-bit divisor, one bit a cycle.
// Depends on prmr_pkg.
`default_nettype none
module prmr_divider
    import prmr_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [2*W-1:0] i_num,
    input  wire logic [W-1:0]   i_den,
    output logic                o_done,
    output logic [2*W-1:0]      o_quo,
    output logic [W-1:0]        o_rem
);
    localparam int unsigned CW = $clog2(2*W+1);
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic [W:0]     r_rem;
    logic [2*W-1:0] r_quo;
    logic [W-1:0]   r_den;
    logic [W:0]     n_shift;

    // One quotient bit per cycle.
    assign n_shift = {r_rem[W-1:0], r_quo[2*W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(2*W);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (n_shift >= {1'b0, r_den}) begin
                    r_rem <= n_shift - {1'b0, r_den};
                    r_quo <= {r_quo[2*W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[2*W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_quo;
    assign o_rem = r_rem[W-1:0];
endmodule
`default_nettype wire

@@ hdl/primitive_root_mod_prime.sv @@
// Top level: smallest primitive root modulo a prime, by a small sequencer.
// Depends on prmr_pkg and prmr_divider.
//
// Channel  Dir  Ports                      Handshake
// input    in   i_modulus                  i_valid / o_stall
// output   out  o_root, o_failed           o_valid / i_stall
//
// Every divide and every modular multiply goes through one bit-serial divider,
// which loads its operands, forms the quotient bits and then signals done.
// Moduli 0, 1, 2 and those above the largest prime go straight to the output
// state once the word is taken; a prime near the top of the range spends most
// of its time in the power loop of the generator search.
// Reset is synchronous and active low; it clears the sequencer.
// The output register holds a result while stalled; the next word is taken
// meanwhile, and its result waits until the output register is free.
`default_nettype none
module primitive_root_mod_prime
    import prmr_pkg::*;
#(
    parameter int unsigned LARGEST_PRIME = LARGEST_PRIME_DEF,
    parameter int unsigned FACTOR_SLOTS  = FACTOR_SLOTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [W-1:0] i_modulus,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [W-1:0]      o_root,
    output logic              o_failed
);
    localparam int unsigned FI = (FACTOR_SLOTS > 1) ? $clog2(FACTOR_SLOTS) : 1;
    localparam int unsigned FC = $clog2(FACTOR_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PRIME, S_PRIME_W, S_FACT, S_FACT_W, S_STRIP_W,
        S_GEN, S_EXP_W, S_POW, S_MUL_W, S_SQR_W, S_OUT
    } t_state;

    t_state           r_state;
    logic [W-1:0]     r_p, r_d, r_v, r_q, r_base, r_acc, r_ex;
    logic [W-1:0]     r_fact [FACTOR_SLOTS];
    logic [FC-1:0]    r_fcnt;
    logic [FI-1:0]    r_fi;
    logic             r_good;
    logic             r_ovalid;
    logic [W-1:0]     r_root;
    logic             r_failed;
    logic             w_load;

    // Divider request.
    logic             r_dstart;
    logic [2*W-1:0]   r_dnum;
    logic [W-1:0]     r_dden;
    logic             w_ddone;
    logic [2*W-1:0]   w_dquo;
    logic [W-1:0]     w_drem;

    // Shared multiplier operands.
    logic [W-1:0]     w_ma;
    logic [W-1:0]     w_mb;
    logic [2*W-1:0]   w_prod;

    prmr_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dnum), .i_den(r_dden),
        .o_done(w_ddone), .o_quo(w_dquo), .o_rem(w_drem)
    );

    // One multiplier serves the square bound and both power-loop products.
    always_comb begin
        case (r_state)
            S_PRIME, S_FACT: begin
                w_ma = r_d;
                w_mb = r_d;
            end
            S_POW: begin
                w_ma = r_ex[0] ? r_acc : r_base;
                w_mb = r_base;
            end
            default: begin
                w_ma = r_base;
                w_mb = r_base;
            end
        endcase
    end
    assign w_prod = 32'(w_ma) * 32'(w_mb);

    assign w_load  = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

    // Sequencer: primality test, factoring, then generator search.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (w_load) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_p <= i_modulus;
                        r_d <= W'(2);
                        if (i_modulus == W'(2)) begin
                            r_root <= W'(1); r_failed <= 1'b0; r_state <= S_OUT;
                        end else if (i_modulus < W'(2) ||
                                     32'(i_modulus) > 32'(LARGEST_PRIME)) begin
                            r_root <= '0; r_failed <= 1'b1; r_state <= S_OUT;
                        end else begin
                            r_state <= S_PRIME;
                        end
                    end
                end
                S_PRIME: begin
                    if (w_prod > 32'(r_p)) begin
                        r_v <= r_p - 1'b1; r_d <= W'(2); r_fcnt <= '0;
                        r_state <= S_FACT;
                    end else begin
                        r_dnum <= 32'(r_p); r_dden <= r_d; r_dstart <= 1'b1;
                        r_state <= S_PRIME_W;
                    end
                end
                S_PRIME_W: if (w_ddone) begin
                    if (w_drem == '0) begin
                        r_root <= '0; r_failed <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_d <= r_d + 1'b1; r_state <= S_PRIME;
                    end
                end
                S_FACT: begin
                    if (w_prod > 32'(r_v)) begin
                        if (r_v > W'(1) && r_fcnt < FC'(FACTOR_SLOTS)) begin
                            r_fact[r_fcnt[FI-1:0]] <= r_v;
                            r_fcnt <= r_fcnt + 1'b1;
                        end
                        r_q <= W'(2); r_fi <= '0; r_good <= 1'b1;
                        r_state <= S_GEN;
                    end else begin
                        r_good <= 1'b0;
                        r_dnum <= 32'(r_v); r_dden <= r_d; r_dstart <= 1'b1;
                        r_state <= S_FACT_W;
                    end
                end
                S_FACT_W: if (w_ddone) begin
                    if (w_drem == '0) begin
                        if (!r_good && r_fcnt < FC'(FACTOR_SLOTS)) begin
                            r_fact[r_fcnt[FI-1:0]] <= r_d;
                            r_fcnt <= r_fcnt + 1'b1;
                        end
                        r_good <= 1'b1;
                        r_v <= w_dquo[W-1:0];
                        r_dnum <= {{W{1'b0}}, w_dquo[W-1:0]};
                        r_dstart <= 1'b1;
                        r_state <= S_FACT_W;
                    end else begin
                        r_d <= r_d + 1'b1; r_state <= S_FACT;
                    end
                end
                S_GEN: begin
                    if (r_q >= r_p) begin
                        r_root <= '0; r_failed <= 1'b1; r_state <= S_OUT;
                    end else if (FC'(r_fi) >= r_fcnt) begin
                        r_root <= r_q; r_failed <= 1'b0; r_state <= S_OUT;
                    end else begin
                        r_dnum <= 32'(r_p - 1'b1); r_dden <= r_fact[r_fi];
                        r_dstart <= 1'b1; r_state <= S_EXP_W;
                    end
                end
                S_EXP_W: if (w_ddone) begin
                    r_ex <= w_dquo[W-1:0]; r_acc <= W'(1); r_base <= r_q;
                    r_state <= S_POW;
                end
                S_POW: begin
                    if (r_ex == '0) begin
                        if (r_acc == W'(1)) begin
                            r_q <= r_q + 1'b1; r_fi <= '0;
                        end else begin
                            r_fi <= r_fi + 1'b1;
                        end
                        r_state <= S_GEN;
                    end else if (r_ex[0]) begin
                        r_dnum <= w_prod; r_dden <= r_p;
                        r_dstart <= 1'b1; r_state <= S_MUL_W;
                    end else begin
                        r_dnum <= w_prod; r_dden <= r_p;
                        r_dstart <= 1'b1; r_state <= S_SQR_W;
                    end
                end
                S_MUL_W: if (w_ddone) begin
                    r_acc <= w_drem;
                    r_dnum <= w_prod;
                    r_dstart <= 1'b1; r_state <= S_SQR_W;
                end
                S_SQR_W: if (w_ddone) begin
                    r_base <= w_drem; r_ex <= r_ex >> 1; r_state <= S_POW;
                end
                S_OUT: begin
                    // Move the result out once the output register is free.
                    if (w_load) begin
                        o_root <= r_root; o_failed <= r_failed; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A word is only taken when the block is free.
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> (r_state == S_IDLE)) else $error("take busy");
    // Output drops only after a hand-off.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result lost");
    // A stalled result does not change.
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_root) && $stable(o_failed)))
        else $error("result changed");
    // In the generator search, the factor count never exceeds the store.
    a_fcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEN) |-> (r_fcnt <= FC'(FACTOR_SLOTS))) else $error("fcnt");
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Testbench for primitive_root_mod_prime: directed moduli, then random ones.
// Depends on prmr_pkg and the RTL of the block; results are checked against
// the directed table's expected words or a predictor written in this file.
`default_nettype none
module tb;
    import prmr_pkg::*;

    localparam int unsigned TOP_PRIME    = LARGEST_PRIME_DEF;
    localparam int unsigned RANDOM_WORDS = 280;
    localparam int unsigned HOLD_CYCLES  = 4000;
    localparam int unsigned CYCLE_LIMIT  = 20000000;
    localparam int unsigned DRAIN_CYCLES = 200;

    typedef struct {
        logic [W-1:0] root;
        logic         failed;
    } t_root_word;

    typedef struct {
        logic [W-1:0] modulus;
        bit           typed;
        logic [W-1:0] root;
        logic         failed;
    } t_modulus_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_stall;
    logic [W-1:0] i_modulus;
    logic         o_valid;
    logic         i_stall;
    logic [W-1:0] o_root;
    logic         o_failed;

    t_modulus_row moduli[$];
    t_root_word   pending_roots[$];
    int unsigned  next_row;
    int unsigned  burst_left;
    int unsigned  gap_left;
    int unsigned  roots_seen;
    int unsigned  hold_left;
    int unsigned  cycle_count;
    bit           hold_started;
    bit           any_error;

    primitive_root_mod_prime dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_modulus (i_modulus),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_root    (o_root),
        .o_failed  (o_failed)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Trial-division primality test.
    function automatic bit is_prime(input int unsigned v);
        int unsigned d;
        if (v < 2) return 1'b0;
        for (d = 2; d * d <= v; d++)
            if (v % d == 0) return 1'b0;
        return 1'b1;
    endfunction

    // Square-and-multiply power modulo m.
    function automatic int unsigned power_mod(input int unsigned b, input int unsigned e,
                                              input int unsigned m);
        int unsigned acc;
        acc = 1 % m;
        b   = b % m;
        while (e != 0) begin
            if (e & 1) acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    // Smallest primitive root of a modulus, or a failure word.
    function automatic t_root_word smallest_root(input logic [W-1:0] modulus);
        t_root_word  r;
        int unsigned p;
        int unsigned v;
        int unsigned d;
        int unsigned q;
        int unsigned i;
        int unsigned factors[$];
        bit          generator;
        p = 32'(modulus);
        r.root   = '0;
        r.failed = 1'b1;
        if (p == 2) begin
            r.root   = W'(1);
            r.failed = 1'b0;
            return r;
        end
        if (p > TOP_PRIME || !is_prime(p)) return r;
        // Distinct prime factors of p-1.
        v = p - 1;
        for (d = 2; d * d <= v; d++) begin
            if (v % d != 0) continue;
            if (factors.size() < FACTOR_SLOTS_DEF) factors.push_back(d);
            while (v % d == 0) v = v / d;
        end
        if (v > 1 && factors.size() < FACTOR_SLOTS_DEF) factors.push_back(v);
        for (q = 2; q < p; q++) begin
            generator = 1'b1;
            for (i = 0; i < factors.size(); i++)
                if (power_mod(q, (p - 1) / factors[i], p) == 1) generator = 1'b0;
            if (generator) begin
                r.root   = W'(q);
                r.failed = 1'b0;
                return r;
            end
        end
        return r;
    endfunction

    function automatic t_modulus_row plain_row(input int unsigned m);
        t_modulus_row row;
        row.modulus = W'(m);
        row.typed   = 1'b0;
        row.root    = '0;
        row.failed  = 1'b0;
        return row;
    endfunction

    function automatic t_modulus_row known_row(input int unsigned m, input int unsigned root,
                                               input bit failed);
        t_modulus_row row;
        row.modulus = W'(m);
        row.typed   = 1'b1;
        row.root    = W'(root);
        row.failed  = failed;
        return row;
    endfunction

    // Stimulus: a directed table, then a random mix.
    initial begin
        int unsigned n;
        int unsigned m;
        int unsigned kind;
        moduli = '{
            known_row(0, 0, 1'b1),      known_row(1, 0, 1'b1),
            known_row(2, 1, 1'b0),      known_row(3, 2, 1'b0),
            known_row(4, 0, 1'b1),      known_row(5, 2, 1'b0),
            known_row(7, 3, 1'b0),      known_row(9, 0, 1'b1),
            known_row(65535, 0, 1'b1),  known_row(65534, 0, 1'b1),
            known_row(65522, 0, 1'b1),  known_row(32768, 0, 1'b1),
            known_row(65520, 0, 1'b1),  plain_row(65521),
            plain_row(65519),           plain_row(257),
            plain_row(65537 - 2),       plain_row(41),
            plain_row(509),             plain_row(30031),
            plain_row(4099),            plain_row(23)
        };
        for (n = 0; n < RANDOM_WORDS; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                m = $urandom_range(0, 65535);
            end else if (kind < 7) begin
                m = $urandom_range(0, 600);
            end else if (kind < 8) begin
                m = $urandom_range(65000, 65535);
            end else begin
                // Well-formed: the next prime at or above a random start.
                m = $urandom_range(3, 5000);
                while (!is_prime(m)) m++;
            end
            moduli.push_back(plain_row(m));
        end
    end

    // Reset, then wait for the last word and a short drain.
    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (next_row == moduli.size() && pending_roots.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!any_error && pending_roots.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Run-length guard.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sender: bursts of words with random gaps between them.
    initial begin
        i_valid    = 1'b0;
        i_modulus  = '0;
        next_row   = 0;
        burst_left = 1;
        gap_left   = 0;
    end
    always @(posedge i_clk) begin
        bit taken;
        taken = i_valid && !o_stall;
        if (i_rst_n) begin
            if (taken) begin
                if (moduli[next_row].typed) begin
                    pending_roots.push_back('{moduli[next_row].root,
                                              moduli[next_row].failed});
                end else begin
                    pending_roots.push_back(smallest_root(moduli[next_row].modulus));
                end
                next_row = next_row + 1;
            end
            if (i_valid && !taken) begin
                // Hold the stalled word.
            end else if (next_row >= moduli.size()) begin
                i_valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end else begin
                i_valid   <= 1'b1;
                i_modulus <= moduli[next_row].modulus;
                burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
    end

    // Long receiver hold-off after some results, so the input backs up.
    initial begin
        hold_left    = 0;
        hold_started = 1'b0;
    end
    always @(posedge i_clk) begin
        if (!hold_started && roots_seen == 30) begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: stall pattern and result check.
    initial begin
        i_stall    = 1'b0;
        roots_seen = 0;
        any_error  = 1'b0;
    end
    always @(posedge i_clk) begin
        t_root_word want;
        if (o_valid && !i_stall) begin
            roots_seen <= roots_seen + 1;
            if (pending_roots.size() == 0) begin
                $error("unexpected word: root %0d failed %0d", o_root, o_failed);
                any_error <= 1'b1;
            end else begin
                want = pending_roots.pop_front();
                if (o_root !== want.root) begin
                    $error("root: expected %0d, got %0d", want.root, o_root);
                    any_error <= 1'b1;
                end
                if (o_failed !== want.failed) begin
                    $error("failed: expected %0d, got %0d", want.failed, o_failed);
                    any_error <= 1'b1;
                end
            end
        end
        // Quiet stretches alternate with busy ones, by cycle count.
        if (hold_left > 0)
            i_stall <= 1'b1;
        else if (cycle_count[9])
            i_stall <= ($urandom_range(0, 2) == 0);
        else
            i_stall <= 1'b0;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/prmr_pkg.sv
hdl/prmr_divider.sv
hdl/primitive_root_mod_prime.sv
bench/tb.sv
